// ===== design/accel_tilt_to_axes_assert.svh =====
// ----------------------------------------------------------------------------
// accel_tilt_to_axes assertion macros
// Concurrent check helpers clocked by clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_TO_AXES_ASSERT_SVH
`define ACCEL_TILT_TO_AXES_ASSERT_SVH

// same-cycle implication
`define ATT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("accel_tilt_to_axes: same-cycle check failed");

// next-cycle implication
`define ATT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("accel_tilt_to_axes: next-cycle check failed");

`endif

// ===== design/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// Shared widths, register indexes, reset values and the arctangent table.
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int OUT_W   = 16;
	localparam int LIMIT_W = 15;
	localparam int GAIN_W  = 17;
	localparam int CFG_W   = 17;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd98301;

	// vectors are scaled to about 2^52 before the rotations
	localparam int VEC_W = 55;
	// angle units: pi = 2^31
	localparam int ANG_W = 34;

	localparam int N_W        = 64;
	localparam int ROOT_W     = 32;
	localparam int REM_W      = 34;
	localparam int SQRT_STEPS = 32;

	typedef enum logic [0:0] {
		CFG_AXIS_LIMIT = 1'b0,
		CFG_ANGLE_GAIN = 1'b1
	} cfg_idx_t;

	// atan(2^-i), pi = 2^31, truncated
	localparam logic [31:0] ATAN_TAB [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

endpackage

// ===== design/att_cordic.sv =====
// ----------------------------------------------------------------------------
// att_cordic
// Pipelined vectoring CORDIC: atan2(num, den), one rotation per stage.
// ----------------------------------------------------------------------------
module att_cordic #(
	parameter int STAGES = att_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [att_pkg::VEC_W-1:0] num,
	input  logic signed [att_pkg::VEC_W-1:0] den,
	output logic signed [att_pkg::ANG_W-1:0] angle
);
	import att_pkg::*;

	localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(64'h8000_0000);

	logic signed [VEC_W-1:0] num_s1, den_s1;
	logic signed [ANG_W-1:0] acc_s1;
	logic                    zero_s1;

	logic signed [VEC_W-1:0] num_s2 [STAGES];
	logic signed [VEC_W-1:0] den_s2 [STAGES];
	logic signed [ANG_W-1:0] acc_s2 [STAGES];
	logic                    zero_s2 [STAGES];

	// fold the left half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (num == '0) && (den == '0);
			if (den < 0) begin
				acc_s1 <= (num >= 0) ? ANG_PI : -ANG_PI;
				den_s1 <= -den;
				num_s1 <= -num;
			end else begin
				acc_s1 <= '0;
				den_s1 <= den;
				num_s1 <= num;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [VEC_W-1:0] num_in, den_in;
		logic signed [ANG_W-1:0] acc_in;
		logic                    zero_in;
		logic signed [ANG_W-1:0] step;

		if (i == 0) begin : g_first
			assign num_in  = num_s1;
			assign den_in  = den_s1;
			assign acc_in  = acc_s1;
			assign zero_in = zero_s1;
		end else begin : g_next
			assign num_in  = num_s2[i-1];
			assign den_in  = den_s2[i-1];
			assign acc_in  = acc_s2[i-1];
			assign zero_in = zero_s2[i-1];
		end

		assign step = ANG_W'(ATAN_TAB[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s2[i] <= zero_in;
				if (num_in > 0) begin
					den_s2[i] <= den_in + (num_in >>> i);
					num_s2[i] <= num_in - (den_in >>> i);
					acc_s2[i] <= acc_in + step;
				end else begin
					den_s2[i] <= den_in - (num_in >>> i);
					num_s2[i] <= num_in + (den_in >>> i);
					acc_s2[i] <= acc_in - step;
				end
			end
		end
	end

	assign angle = zero_s2[STAGES-1] ? '0 : acc_s2[STAGES-1];

endmodule

// ===== design/accel_tilt_to_axes.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_to_axes
// Accelerometer sample to two joystick axes via square root and CORDIC.
//
// Takes one signed x, y, z sample per word and returns tilt_x =
// atan2(x, sqrt(y^2+z^2)) and tilt_y = atan2(y, z), each as a fraction of pi
// times angle_gain, truncated toward zero and clamped to +-axis_limit. A new
// sample is taken every cycle while the output side keeps up. The squares
// and their sum are registered, then come SQRT_STEPS square root stages
// of one result bit each, a fold stage plus CORDIC_STAGES stages for the
// rotation pipelines, then the gain multiply and the clamp. The whole pipeline
// holds while a finished word waits at the output. Write axis_limit and
// angle_gain only while no sample is in flight.
// ----------------------------------------------------------------------------
`include "accel_tilt_to_axes_assert.svh"

module accel_tilt_to_axes #(
	parameter int SAMPLE_BITS   = att_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STAGES = att_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_BITS-1:0]    accel_x,
	input  logic signed [SAMPLE_BITS-1:0]    accel_y,
	input  logic signed [SAMPLE_BITS-1:0]    accel_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [att_pkg::OUT_W-1:0] tilt_x,
	output logic signed [att_pkg::OUT_W-1:0] tilt_y,
	input  logic                             cfg_we,
	input  att_pkg::cfg_idx_t                cfg_index,
	input  logic [att_pkg::CFG_W-1:0]        cfg_data
);
	import att_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int SHIFT_S = 32 - SB;
	localparam int PRE     = 52 - SB;
	localparam int DEPTH   = 2 + SQRT_STEPS + 1 + CORDIC_STAGES + 2;
	localparam int MAG_W   = ANG_W - 1;
	localparam int PROD_W  = MAG_W + GAIN_W;
	localparam int Q_W     = PROD_W - 31;

	function automatic logic signed [OUT_W-1:0] clamp_axis(
		input logic [PROD_W-1:0]  prod,
		input logic               neg,
		input logic [LIMIT_W-1:0] lim
	);
		logic [Q_W-1:0]     q;
		logic [LIMIT_W-1:0] v;
		q = prod[PROD_W-1:31];
		v = (q > Q_W'(lim)) ? lim : q[LIMIT_W-1:0];
		return neg ? -OUT_W'(v) : OUT_W'(v);
	endfunction

	logic               adv;
	logic [DEPTH-1:0]   vld_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [GAIN_W-1:0]  gain_q;

	assign adv       = !vld_q[DEPTH-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			gain_q  <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AXIS_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_ANGLE_GAIN: gain_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// squares
	logic signed [2*SB-1:0] yy, zz;
	logic [2*SB-1:0]        yy_s1, zz_s1;
	logic signed [SB-1:0]   x_s1, y_s1, z_s1;

	assign yy = accel_y * accel_y;
	assign zz = accel_z * accel_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			yy_s1 <= yy;
			zz_s1 <= zz;
			x_s1  <= accel_x;
			y_s1  <= accel_y;
			z_s1  <= accel_z;
		end
	end

	// radicand
	logic [N_W-1:0]       n_s2;
	logic signed [SB-1:0] x_s2, y_s2, z_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s2 <= (N_W'(yy_s1) + N_W'(zz_s1)) << (2 * SHIFT_S);
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
		end
	end

	// square root, one result bit per stage
	logic [REM_W-1:0]     rem_s3  [SQRT_STEPS-1];
	logic [N_W-1:0]       n_s3    [SQRT_STEPS-1];
	logic [ROOT_W-1:0]    root_s3 [SQRT_STEPS];
	logic signed [SB-1:0] x_s3    [SQRT_STEPS];
	logic signed [SB-1:0] y_s3    [SQRT_STEPS];
	logic signed [SB-1:0] z_s3    [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [REM_W-1:0]     rem_in;
		logic [N_W-1:0]       n_in;
		logic [ROOT_W-1:0]    root_in;
		logic signed [SB-1:0] x_in, y_in, z_in;
		logic [REM_W:0]       r2, trial;
		logic                 ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign n_in    = n_s2;
			assign root_in = '0;
			assign x_in    = x_s2;
			assign y_in    = y_s2;
			assign z_in    = z_s2;
		end else begin : g_next
			assign rem_in  = rem_s3[k-1];
			assign n_in    = n_s3[k-1];
			assign root_in = root_s3[k-1];
			assign x_in    = x_s3[k-1];
			assign y_in    = y_s3[k-1];
			assign z_in    = z_s3[k-1];
		end

		assign r2    = {rem_in[REM_W-2:0], n_in[N_W-1:N_W-2]};
		assign trial = (REM_W+1)'({root_in, 2'b01});
		assign ge    = r2 >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s3[k] <= {root_in[ROOT_W-2:0], ge};
				x_s3[k]    <= x_in;
				y_s3[k]    <= y_in;
				z_s3[k]    <= z_in;
			end
		end

		if (k < SQRT_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s3[k] <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
					n_s3[k]   <= n_in << 2;
				end
			end
		end
	end

	// rotations
	logic signed [VEC_W-1:0] num_x, den_x, num_y, den_y;
	logic signed [ANG_W-1:0] ang_x, ang_y;

	assign num_x = VEC_W'(x_s3[SQRT_STEPS-1]) <<< PRE;
	assign den_x = VEC_W'({root_s3[SQRT_STEPS-1], 20'b0});
	assign num_y = VEC_W'(y_s3[SQRT_STEPS-1]) <<< PRE;
	assign den_y = VEC_W'(z_s3[SQRT_STEPS-1]) <<< PRE;

	att_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
		.clk   (clk),
		.en    (adv),
		.num   (num_x),
		.den   (den_x),
		.angle (ang_x)
	);

	att_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
		.clk   (clk),
		.en    (adv),
		.num   (num_y),
		.den   (den_y),
		.angle (ang_y)
	);

	// gain
	logic [MAG_W-1:0]  mag_x, mag_y;
	logic [PROD_W-1:0] prod_x_s6, prod_y_s6;
	logic              neg_x_s6, neg_y_s6;

	assign mag_x = (ang_x < 0) ? MAG_W'(-ang_x) : MAG_W'(ang_x);
	assign mag_y = (ang_y < 0) ? MAG_W'(-ang_y) : MAG_W'(ang_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s6 <= PROD_W'(mag_x) * PROD_W'(gain_q);
			prod_y_s6 <= PROD_W'(mag_y) * PROD_W'(gain_q);
			neg_x_s6  <= ang_x < 0;
			neg_y_s6  <= ang_y < 0;
		end
	end

	// clamp, output word
	logic signed [OUT_W-1:0] tilt_x_s7, tilt_y_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			tilt_x_s7 <= clamp_axis(prod_x_s6, neg_x_s6, limit_q);
			tilt_y_s7 <= clamp_axis(prod_y_s6, neg_y_s6, limit_q);
		end
	end

	assign tilt_x = tilt_x_s7;
	assign tilt_y = tilt_y_s7;

	logic signed [OUT_W-1:0] lim_signed;
	assign lim_signed = OUT_W'(limit_q);

	`ATT_ASSERT_IMPL(a_tilt_x_range, out_valid, (tilt_x <= lim_signed) && (tilt_x >= -lim_signed))
	`ATT_ASSERT_IMPL(a_tilt_y_range, out_valid, (tilt_y <= lim_signed) && (tilt_y >= -lim_signed))
	`ATT_ASSERT_NEXT(a_limit_write, cfg_we && (cfg_index == CFG_AXIS_LIMIT), limit_q == $past(cfg_data[LIMIT_W-1:0]))

endmodule

// ===== test/tb_accel_tilt_to_axes.sv =====
// ----------------------------------------------------------------------------
// tb_accel_tilt_to_axes
// Drives accelerometer samples through the tilt-to-axes block with random
// idling on both sides and checks every output word against a bit-accurate
// square root, CORDIC and gain/clamp predictor kept in the testbench.
// ----------------------------------------------------------------------------
module tb_accel_tilt_to_axes;
	timeunit 1ns;
	timeprecision 1ps;
	import att_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int NST = CORDIC_STAGES_DEF;
	localparam int LAT = 37 + NST;

	typedef struct packed {
		logic signed [OUT_W-1:0] tx;
		logic signed [OUT_W-1:0] ty;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SB-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] tilt_x, tilt_y;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_AXIS_LIMIT;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [LIMIT_W-1:0] lim_q = LIMIT_RESET;
	logic [GAIN_W-1:0] gain_q = GAIN_RESET;
	tilt_t tilt_q[$];
	int n_err = 0;
	int sink_gap = 0;
	bit quiet = 1'b0;
	int hold_cycles = 0;

	always #2 clk = ~clk;

	accel_tilt_to_axes u_dut (.*);

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vec_angle(longint num, longint den);
		longint acc, dn, nn;
		acc = 0;
		if (num == 0 && den == 0) return 0;
		if (den < 0) begin
			acc = (num >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
			den = -den;
			num = -num;
		end
		for (int i = 0; i < NST && i < 24; i++) begin
			dn = shr_floor(den, i);
			nn = shr_floor(num, i);
			if (num > 0) begin
				den = den + nn;
				num = num - dn;
				acc += longint'(ATAN_TAB[i]);
			end else begin
				den = den - nn;
				num = num + dn;
				acc -= longint'(ATAN_TAB[i]);
			end
		end
		return acc;
	endfunction

	function automatic logic signed [OUT_W-1:0] gain_clamp(longint ang);
		longint unsigned mag;
		longint v, lim;
		mag = (ang < 0) ? longint'(-ang) : ang;
		mag = (mag * longint'(gain_q)) >> 31;
		v = (ang < 0) ? -longint'(mag) : longint'(mag);
		lim = longint'(lim_q);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[OUT_W-1:0];
	endfunction

	function automatic tilt_t tilt_of(logic signed [SB-1:0] x, y, z);
		longint xl, yl, zl, m, pre;
		longint unsigned sq;
		tilt_t t;
		xl = x; yl = y; zl = z;
		sq = longint'(yl * yl) + longint'(zl * zl);
		m = root64(sq << (2 * (32 - SB)));
		pre = 64'sd1 <<< (52 - SB);
		t.tx = gain_clamp(vec_angle((xl <<< (32 - SB)) <<< 20, m <<< 20));
		t.ty = gain_clamp(vec_angle(yl * pre, zl * pre));
		return t;
	endfunction

	task automatic send_sample(logic signed [SB-1:0] x, y, z);
		int g;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			g = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x; accel_y <= y; accel_z <= z;
		tilt_q.insert(tilt_q.size(), tilt_of(x, y, z));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_AXIS_LIMIT) lim_q = v[LIMIT_W-1:0];
		else gain_q = v[GAIN_W-1:0];
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tilt_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic logic signed [SB-1:0] rnd_sample();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
			1: return $urandom_range(0, 1) ? SB'(0) : SB'(int'($urandom_range(0, 7)) - 4);
			default: return SB'($urandom());
		endcase
	endfunction

	task automatic test_directed();
		logic signed [SB-1:0] mx, mn;
		mx = {1'b0, {(SB-1){1'b1}}};
		mn = {1'b1, {(SB-1){1'b0}}};
		send_sample(0, 0, 0);
		send_sample(mx, 0, 0);
		send_sample(mn, 0, 0);
		send_sample(0, mx, 0);
		send_sample(0, mn, 0);
		send_sample(0, 0, mx);
		send_sample(0, 0, mn);
		send_sample(mx, mx, mx);
		send_sample(mn, mn, mn);
		send_sample(100, 0, -100);
		send_sample(-100, -5, -100);
		send_sample(7, 5, -1);
		send_sample(-1, -1, -1);
		send_sample(1, 1, 1);
		send_sample(mx, mn, mx);
		send_sample(16384, 0, 16384);
		send_sample(-16384, 16384, 0);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_sample(rnd_sample(), rnd_sample(), rnd_sample());
		drain();
	endtask

	task automatic test_settings();
		write_reg(CFG_AXIS_LIMIT, 1);
		write_reg(CFG_ANGLE_GAIN, 131071);
		test_random(60);
		write_reg(CFG_AXIS_LIMIT, 0);
		test_random(20);
		write_reg(CFG_AXIS_LIMIT, 32767);
		write_reg(CFG_ANGLE_GAIN, 1);
		test_random(40);
		write_reg(CFG_ANGLE_GAIN, 0);
		test_random(20);
		write_reg(CFG_AXIS_LIMIT, CFG_W'($urandom_range(1, 32767)));
		write_reg(CFG_ANGLE_GAIN, CFG_W'($urandom_range(1, 131071)));
		test_random(80);
		write_reg(CFG_AXIS_LIMIT, CFG_W'(LIMIT_RESET));
		write_reg(CFG_ANGLE_GAIN, CFG_W'(GAIN_RESET));
	endtask

	task automatic test_backpressure();
		hold_cycles = 3 * LAT;
		test_random(120);
	endtask

	// output side stall pattern
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			sink_gap <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tilt_t e;
		if (arst_n && out_valid && out_ready) begin
			if (tilt_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected word %0d %0d", tilt_x, tilt_y);
			end else begin
				e = tilt_q.pop_front();
				if (e.tx !== tilt_x || e.ty !== tilt_y) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: tilt_x exp %0d got %0d, tilt_y exp %0d got %0d",
							e.tx, tilt_x, e.ty, tilt_y);
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		test_settings();
		test_backpressure();
		quiet = 1'b1;
		test_random(60);
		if (n_err == 0 && tilt_q.size() == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
